FILE: rtl/sgpa_pkg.sv
// ----------------------------------------------------------------------------
// sgpa_pkg: shared types and constants
// Queue word, back-end sequencer states and register codes for the
// softened gravity pair accumulator.
// ----------------------------------------------------------------------------
package sgpa_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 56;

  localparam logic [CFG_IDX_W-1:0] CFG_SOFTENING = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MASS      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SELF_POT  = 2'd2;

  localparam int SUM_W = 48;
  localparam int NUM_W = 117;  // (m * |d|) << 53
  localparam int DEN_W = 96;   // r2 * r

  // one classified pair: distance magnitudes, "d > 0" flags, row end
  typedef struct packed {
    logic [31:0] ad_x;
    logic [31:0] ad_y;
    logic [31:0] ad_z;
    logic        pos_x;
    logic        pos_y;
    logic        pos_z;
    logic        last;
  } front_word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ,
    ST_CHK,
    ST_SQRT,
    ST_R3,
    ST_MP,
    ST_DIVLD,
    ST_DIV,
    ST_ACC,
    ST_FIN
  } back_state_t;

endpackage

FILE: rtl/softened_gravity_pair_accumulator_core.sv
// ----------------------------------------------------------------------------
// softened_gravity_pair_accumulator_core: N-body force row accumulator
// Sums softened gravity acceleration and potential over one target row.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one word per (i, j) pair:
//   positions in signed Q7.24 plus last_of_row on the row's final source.
//   Output channel (out_valid/out_ready) gives one word per row: the three
//   acceleration sums and the potential (self term added), Q15.32, and a
//   saturated flag if any sum clipped during the row.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
//   eps^2, G*m and the self potential; always ready, write only when idle.
// Sequence:
//   For each pair the sequencer forms the squares, the root, r^3 and
//   four divisions; the squares and r^3 use the one 32x32 multiplier.
//   A pair with zero r2 skips to the finish. The classifier and queue
//   take new pairs while the sequencer is busy, until the queue is full.
//   A row result is registered as its last pair finishes.
// Reset clears the sums, the queue and the output valid flag and loads the
// default registers. A stalled output word holds; the sequencer keeps
// working on the next row and waits only if a second row result is ready.
// ----------------------------------------------------------------------------
module softened_gravity_pair_accumulator_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [31:0]                  i_x,
  input  logic signed [31:0]                  i_y,
  input  logic signed [31:0]                  i_z,
  input  logic signed [31:0]                  j_x,
  input  logic signed [31:0]                  j_y,
  input  logic signed [31:0]                  j_z,
  input  logic                                last_of_row,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [47:0]                  acc_x,
  output logic signed [47:0]                  acc_y,
  output logic signed [47:0]                  acc_z,
  output logic signed [47:0]                  potential,
  output logic                                saturated,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sgpa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sgpa_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // configuration registers
  logic [55:0] softening_squared;
  logic [31:0] particle_mass;
  logic [46:0] self_potential;

  sgpa_pkg::front_word_t in_word;
  sgpa_pkg::front_word_t q_word;
  logic push;
  logic pop;
  logic fifo_full;
  logic fifo_empty;

  assign cfg_ready = 1'b1;
  assign in_ready  = !fifo_full;
  assign push      = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      softening_squared <= 56'd6200640000;
      particle_mass     <= 32'd167772;
      self_potential    <= 47'd9150857321;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sgpa_pkg::CFG_SOFTENING: softening_squared <= cfg_data;
        sgpa_pkg::CFG_MASS:      particle_mass     <= cfg_data[31:0];
        sgpa_pkg::CFG_SELF_POT:  self_potential    <= cfg_data[46:0];
        default: ;  // unused index
      endcase
    end
  end

  // front: difference and sign per axis
  sgpa_front u_front (
    .i_x         (i_x),
    .i_y         (i_y),
    .i_z         (i_z),
    .j_x         (j_x),
    .j_y         (j_y),
    .j_z         (j_z),
    .last_of_row (last_of_row),
    .word        (in_word)
  );

  // decoupling queue
  sgpa_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_word (in_word),
    .pop     (pop),
    .rd_word (q_word),
    .full    (fifo_full),
    .empty   (fifo_empty)
  );

  // back: sqrt, divides, saturating sums, output register
  sgpa_back u_back (
    .clk               (clk),
    .rst               (rst),
    .softening_squared (softening_squared),
    .particle_mass     (particle_mass),
    .self_potential    (self_potential),
    .word              (q_word),
    .empty             (fifo_empty),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .acc_x             (acc_x),
    .acc_y             (acc_y),
    .acc_z             (acc_z),
    .potential         (potential),
    .saturated         (saturated)
  );

`ifndef ASSERT_OFF
  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !fifo_empty)
    else $error("pop from empty queue");

  a_queue_flags: assert property (@(posedge clk) disable iff (rst)
    !(fifo_full && fifo_empty))
    else $error("queue both full and empty");

  a_pop_one_gap: assert property (@(posedge clk) disable iff (rst)
    pop |=> !pop)
    else $error("sequencer took two words back to back");
`endif

endmodule

FILE: rtl/sgpa_front.sv
// ----------------------------------------------------------------------------
// sgpa_front: pair classifier
// Forms d = i - j per axis, splits it into magnitude and sign, and hands
// the word to the queue.
// ----------------------------------------------------------------------------
module sgpa_front (
  input  logic signed [31:0] i_x,
  input  logic signed [31:0] i_y,
  input  logic signed [31:0] i_z,
  input  logic signed [31:0] j_x,
  input  logic signed [31:0] j_y,
  input  logic signed [31:0] j_z,
  input  logic               last_of_row,
  output sgpa_pkg::front_word_t word
);

  logic signed [32:0] dx, dy, dz;
  logic        [32:0] nx, ny, nz;

  assign dx = {i_x[31], i_x} - {j_x[31], j_x};
  assign dy = {i_y[31], i_y} - {j_y[31], j_y};
  assign dz = {i_z[31], i_z} - {j_z[31], j_z};

  assign nx = -dx;
  assign ny = -dy;
  assign nz = -dz;

  always_comb begin
    word.ad_x  = dx[32] ? nx[31:0] : dx[31:0];
    word.ad_y  = dy[32] ? ny[31:0] : dy[31:0];
    word.ad_z  = dz[32] ? nz[31:0] : dz[31:0];
    word.pos_x = !dx[32] && (dx != '0);
    word.pos_y = !dy[32] && (dy != '0);
    word.pos_z = !dz[32] && (dz != '0);
    word.last  = last_of_row;
  end

endmodule

FILE: rtl/sgpa_fifo.sv
// ----------------------------------------------------------------------------
// sgpa_fifo: pair queue
// Small register queue between the classifier and the sequencer.
// ----------------------------------------------------------------------------
module sgpa_fifo #(
  parameter int DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  sgpa_pkg::front_word_t wr_word,
  input  logic                  pop,
  output sgpa_pkg::front_word_t rd_word,
  output logic                  full,
  output logic                  empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  sgpa_pkg::front_word_t mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign rd_word = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_word;
    end
  end

endmodule

FILE: rtl/sgpa_back.sv
// ----------------------------------------------------------------------------
// sgpa_back: force sequencer
// Squares, bit-serial square root, r^3, four radix-2 divisions and the
// saturating row sums; squares, r^3 and m*|d| share one 32x32 multiplier.
// ----------------------------------------------------------------------------
module sgpa_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [55:0]           softening_squared,
  input  logic [31:0]           particle_mass,
  input  logic [46:0]           self_potential,
  input  sgpa_pkg::front_word_t word,
  input  logic                  empty,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [47:0]    acc_x,
  output logic signed [47:0]    acc_y,
  output logic signed [47:0]    acc_z,
  output logic signed [47:0]    potential,
  output logic                  saturated
);

  localparam int NW = sgpa_pkg::NUM_W;
  localparam int DW = sgpa_pkg::DEN_W;
  localparam logic [48:0] MAG_CAP = 49'h1_0000_0000_0000;
  localparam logic signed [49:0] SAT_HI = 50'sd140737488355327;
  localparam logic signed [49:0] SAT_LO = -50'sd140737488355328;

  sgpa_pkg::back_state_t state, state_next;

  logic [6:0]  cnt;
  logic [1:0]  t;
  logic [31:0] ad0, ad1, ad2;
  logic        pos0, pos1, pos2;
  logic        last_r;
  logic [63:0] r2;
  logic [63:0] sq_src;
  logic [33:0] sq_rem;
  logic [31:0] root;
  logic [95:0] r3;
  logic [63:0] prod;
  logic [NW-1:0] num;
  logic [DW-1:0] den;
  logic [DW-1:0] rem;
  logic [48:0] q;
  logic        over;
  logic [47:0] sum_x, sum_y, sum_z, sum_pot;
  logic        clip;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [35:0] sq_sh, sq_trial, sq_diff;
  logic        sq_ge;
  logic [DW:0] dv_sh, dv_diff;
  logic        dv_ge;
  logic [49:0] q_sh;
  logic [47:0] acc_sel;
  logic        acc_neg;
  logic [48:0] acc_res;
  logic signed [48:0] fin_pot;
  logic        can_emit;

  // {clip, value}: add a capped signed magnitude to a 48-bit sum
  function automatic logic [48:0] sat_add(input logic [47:0] sum, input logic neg,
                                          input logic [48:0] mag);
    logic signed [49:0] tm;
    logic signed [49:0] s;
    logic [48:0] r;
    tm = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    s  = $signed({{2{sum[47]}}, sum}) + tm;
    if (s > SAT_HI) begin
      r = {1'b1, SAT_HI[47:0]};
    end else if (s < SAT_LO) begin
      r = {1'b1, SAT_LO[47:0]};
    end else begin
      r = {1'b0, s[47:0]};
    end
    return r;
  endfunction

  // shared multiplier operand select
  always_comb begin
    mul_a = ad0;
    mul_b = ad0;
    case (state)
      sgpa_pkg::ST_R3: begin
        mul_a = cnt[0] ? r2[63:32] : r2[31:0];
        mul_b = root;
      end
      sgpa_pkg::ST_MP: begin
        mul_a = particle_mass;
        mul_b = ad0;
      end
      default: ;
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // one root bit per cycle
  assign sq_sh    = {sq_rem, sq_src[63:62]};
  assign sq_trial = {2'b00, root, 2'b01};
  assign sq_ge    = (sq_sh >= sq_trial);
  assign sq_diff  = sq_sh - sq_trial;

  // one quotient bit per cycle, quotient held at the cap once past it
  assign dv_sh   = {rem, num[NW-1]};
  assign dv_ge   = (dv_sh >= {1'b0, den});
  assign dv_diff = dv_sh - {1'b0, den};
  assign q_sh    = {q, dv_ge};

  always_comb begin
    acc_sel = sum_pot;
    acc_neg = 1'b1;
    if (t != 2'd3) begin
      acc_neg = pos0;
      case (t)
        2'd0:    acc_sel = sum_x;
        2'd1:    acc_sel = sum_y;
        default: acc_sel = sum_z;
      endcase
    end
  end
  assign acc_res = sat_add(acc_sel, acc_neg, q);

  assign fin_pot  = $signed({sum_pot[47], sum_pot}) + $signed({2'b00, self_potential});
  assign can_emit = !out_valid || out_ready;
  assign pop      = (state == sgpa_pkg::ST_IDLE) && !empty;

  always_comb begin
    state_next = state;
    case (state)
      sgpa_pkg::ST_IDLE:  if (!empty) state_next = sgpa_pkg::ST_SQ;
      sgpa_pkg::ST_SQ:    if (cnt == 7'd3) state_next = sgpa_pkg::ST_CHK;
      sgpa_pkg::ST_CHK:   state_next = (r2 == '0) ? sgpa_pkg::ST_FIN : sgpa_pkg::ST_SQRT;
      sgpa_pkg::ST_SQRT:  if (cnt == 7'd31) state_next = sgpa_pkg::ST_R3;
      sgpa_pkg::ST_R3:    if (cnt == 7'd2) state_next = sgpa_pkg::ST_MP;
      sgpa_pkg::ST_MP:    state_next = sgpa_pkg::ST_DIVLD;
      sgpa_pkg::ST_DIVLD: state_next = sgpa_pkg::ST_DIV;
      sgpa_pkg::ST_DIV:   if (cnt == 7'(NW - 1)) state_next = sgpa_pkg::ST_ACC;
      sgpa_pkg::ST_ACC:   state_next = (t == 2'd3) ? sgpa_pkg::ST_FIN : sgpa_pkg::ST_MP;
      sgpa_pkg::ST_FIN:   if (!last_r || can_emit) state_next = sgpa_pkg::ST_IDLE;
      default:            state_next = sgpa_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sgpa_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // row sums and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_x     <= '0;
      sum_y     <= '0;
      sum_z     <= '0;
      sum_pot   <= '0;
      clip      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (state == sgpa_pkg::ST_FIN && last_r && can_emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (state == sgpa_pkg::ST_ACC) begin
        clip <= clip | acc_res[48];
        case (t)
          2'd0:    sum_x   <= acc_res[47:0];
          2'd1:    sum_y   <= acc_res[47:0];
          2'd2:    sum_z   <= acc_res[47:0];
          default: sum_pot <= acc_res[47:0];
        endcase
      end
      if (state == sgpa_pkg::ST_FIN && last_r && can_emit) begin
        sum_x     <= '0;
        sum_y     <= '0;
        sum_z     <= '0;
        sum_pot   <= '0;
        clip      <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == sgpa_pkg::ST_FIN && last_r && can_emit) begin
      acc_x <= sum_x;
      acc_y <= sum_y;
      acc_z <= sum_z;
      if (fin_pot > $signed({1'b0, SAT_HI[47:0]})) begin
        potential <= SAT_HI[47:0];
        saturated <= 1'b1;
      end else begin
        potential <= fin_pot[47:0];
        saturated <= clip;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    prod <= mul_p;
    case (state)
      sgpa_pkg::ST_IDLE: begin
        ad0    <= word.ad_x;
        ad1    <= word.ad_y;
        ad2    <= word.ad_z;
        pos0   <= word.pos_x;
        pos1   <= word.pos_y;
        pos2   <= word.pos_z;
        last_r <= word.last;
        r2     <= {10'd0, softening_squared[55:2]};
        cnt    <= '0;
      end
      sgpa_pkg::ST_SQ: begin
        if (cnt != 7'd3) begin
          ad0  <= ad1;
          ad1  <= ad2;
          ad2  <= ad0;
        end
        if (cnt != 7'd0) begin
          r2 <= r2 + {2'b00, prod[63:2]};
        end
        cnt <= (cnt == 7'd3) ? '0 : cnt + 1'b1;
      end
      sgpa_pkg::ST_CHK: begin
        sq_src <= r2;
        sq_rem <= '0;
        root   <= '0;
        cnt    <= '0;
      end
      sgpa_pkg::ST_SQRT: begin
        sq_rem <= sq_ge ? sq_diff[33:0] : sq_sh[33:0];
        root   <= {root[30:0], sq_ge};
        sq_src <= {sq_src[61:0], 2'b00};
        cnt    <= (cnt == 7'd31) ? '0 : cnt + 1'b1;
      end
      sgpa_pkg::ST_R3: begin
        if (cnt == 7'd1) begin
          r3 <= {32'd0, prod};
        end
        if (cnt == 7'd2) begin
          r3 <= r3 + {prod, 32'd0};
        end
        cnt <= (cnt == 7'd2) ? '0 : cnt + 1'b1;
        t   <= 2'd0;
      end
      sgpa_pkg::ST_DIVLD: begin
        if (t == 2'd3) begin
          num <= {54'd0, particle_mass, 31'd0};
          den <= {64'd0, root};
        end else begin
          num <= {prod, 53'd0};
          den <= r3;
        end
        rem  <= '0;
        q    <= '0;
        over <= 1'b0;
        cnt  <= '0;
      end
      sgpa_pkg::ST_DIV: begin
        rem <= dv_ge ? dv_diff[DW-1:0] : dv_sh[DW-1:0];
        num <= {num[NW-2:0], 1'b0};
        if (!over) begin
          if (q_sh > {1'b0, MAG_CAP}) begin
            q    <= MAG_CAP;
            over <= 1'b1;
          end else begin
            q <= q_sh[48:0];
          end
        end
        cnt <= (cnt == 7'(NW - 1)) ? '0 : cnt + 1'b1;
      end
      sgpa_pkg::ST_ACC: begin
        if (t != 2'd3) begin
          ad0  <= ad1;
          ad1  <= ad2;
          ad2  <= ad0;
          pos0 <= pos1;
          pos1 <= pos2;
          pos2 <= pos0;
        end
        t <= t + 1'b1;
      end
      default: ;
    endcase
  end

endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: softened gravity pair accumulator core
// Streams directed and random (i, j) pair rows into the core under random
// idling on both channels, predicts each row result with an internal
// fixed-point model and checks every returned word field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

  localparam logic [sgpa_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;  // no register here
  localparam int SETTLE = 1200;                                  // > two pair times

  // expected row result
  typedef struct {
    logic [47:0] ax, ay, az, pot;
    logic        sat;
  } row_sum_t;

  // force row predictor plus the queue of row sums still owed by the core
  class row_scoreboard;
    logic [55:0] eps_sq = 56'd6200640000;
    logic [31:0] mass   = 32'd167772;
    logic [46:0] self_p = 47'd9150857321;
    longint sx, sy, sz, sp;
    bit clip;
    row_sum_t owed[$];
    int errors;

    function void write_reg(logic [sgpa_pkg::CFG_IDX_W-1:0] idx, logic [55:0] val);
      case (idx)
        sgpa_pkg::CFG_SOFTENING: eps_sq = val;
        sgpa_pkg::CFG_MASS:      mass = val[31:0];
        sgpa_pkg::CFG_SELF_POT:  self_p = val[46:0];
        default: ;
      endcase
    endfunction

    function bit [63:0] root(bit [63:0] x);
      bit [63:0] res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
        if (x >= res + b) begin
          x = x - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return root_ret(res);
    endfunction

    function bit [63:0] root_ret(bit [63:0] v);
      return v;
    endfunction

    // clamp the term magnitude, then the running sum
    function longint add_sat(longint sum, bit neg, bit [127:0] mag);
      longint t, s;
      if (mag > (128'd1 << 48)) mag = 128'd1 << 48;
      t = neg ? -longint'(mag[63:0]) : longint'(mag[63:0]);
      s = sum + t;
      if (s > 64'sh7FFF_FFFF_FFFF) begin
        s = 64'sh7FFF_FFFF_FFFF;
        clip = 1;
      end
      if (s < -64'sh8000_0000_0000) begin
        s = -64'sh8000_0000_0000;
        clip = 1;
      end
      return s;
    endfunction

    function longint acc_add(longint sum, longint d, bit [127:0] r3);
      bit [63:0] ad;
      bit [127:0] num;
      ad = d < 0 ? -d : d;
      num = (128'(mass) * 128'(ad)) << 53;
      // force points from i toward j: negative when d > 0
      return add_sat(sum, d > 0, num / r3);
    endfunction

    function void note_pair(logic signed [31:0] ix, iy, iz, jx, jy, jz, logic last);
      longint dx, dy, dz, p;
      bit [63:0] ax, ay, az, r2, r, pot;
      bit [127:0] r3;
      row_sum_t e;
      dx = longint'(ix) - longint'(jx);
      dy = longint'(iy) - longint'(jy);
      dz = longint'(iz) - longint'(jz);
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      az = dz < 0 ? -dz : dz;
      // 64-bit wrap on the sum is part of the datapath
      r2 = ((ax * ax) >> 2) + ((ay * ay) >> 2) + ((az * az) >> 2) + (64'(eps_sq) >> 2);
      if (r2 != 0) begin
        r = root(r2);
        r3 = 128'(r2) * 128'(r);
        pot = (64'(mass) << 31) / r;
        sx = acc_add(sx, dx, r3);
        sy = acc_add(sy, dy, r3);
        sz = acc_add(sz, dz, r3);
        sp = add_sat(sp, 1'b1, 128'(pot));
      end
      if (!last) return;
      e.sat = clip;
      p = sp + longint'(self_p);
      if (p > 64'sh7FFF_FFFF_FFFF) begin
        p = 64'sh7FFF_FFFF_FFFF;
        e.sat = 1;
      end
      e.ax = sx[47:0];
      e.ay = sy[47:0];
      e.az = sz[47:0];
      e.pot = p[47:0];
      owed.push_back(e);
      sx = 0; sy = 0; sz = 0; sp = 0;
      clip = 0;
    endfunction

    function void check_row(logic [47:0] ax, ay, az, pot, logic sat);
      row_sum_t e;
      if (owed.size() == 0) begin
        $display("%0t: unexpected row word acc=%h %h %h pot=%h sat=%b",
                 $time, ax, ay, az, pot, sat);
        errors++;
        return;
      end
      e = owed.pop_front();
      if (ax !== e.ax) begin
        $display("%0t: acc_x exp %h got %h", $time, e.ax, ax);
        errors++;
      end
      if (ay !== e.ay) begin
        $display("%0t: acc_y exp %h got %h", $time, e.ay, ay);
        errors++;
      end
      if (az !== e.az) begin
        $display("%0t: acc_z exp %h got %h", $time, e.az, az);
        errors++;
      end
      if (pot !== e.pot) begin
        $display("%0t: potential exp %h got %h", $time, e.pot, pot);
        errors++;
      end
      if (sat !== e.sat) begin
        $display("%0t: saturated exp %b got %b", $time, e.sat, sat);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_ready;
  logic signed [31:0] i_x = 0, i_y = 0, i_z = 0, j_x = 0, j_y = 0, j_z = 0;
  logic last_of_row = 0;
  logic out_valid, out_ready = 0;
  logic signed [47:0] acc_x, acc_y, acc_z, potential;
  logic saturated;
  logic cfg_valid = 0, cfg_ready;
  logic [sgpa_pkg::CFG_IDX_W-1:0] cfg_index = 0;
  logic [sgpa_pkg::CFG_DATA_W-1:0] cfg_data = 0;

  int send_idle, recv_idle;  // percent of cycles each side idles
  row_scoreboard sb = new();

  softened_gravity_pair_accumulator_core dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // receiver: random backpressure
  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_idle);

  // monitor: handshakes sampled on the edge, pre-update values
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready)
      sb.note_pair(i_x, i_y, i_z, j_x, j_y, j_z, last_of_row);
    if (!rst && out_valid && out_ready)
      sb.check_row(acc_x, acc_y, acc_z, potential, saturated);
  end

  // one pair word; valid stays up across back-to-back words
  task automatic send_pair(logic signed [31:0] ix, iy, iz, jx, jy, jz, logic last);
    bit got;
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    in_valid <= 1;
    i_x <= ix; i_y <= iy; i_z <= iz;
    j_x <= jx; j_y <= jy; j_z <= jz;
    last_of_row <= last;
    do begin
      @(negedge clk);
      got = in_ready;
      @(posedge clk);
    end while (!got);
  endtask

  // let the core finish every row, then the trailing latency
  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [sgpa_pkg::CFG_IDX_W-1:0] idx, logic [55:0] val);
    bit got;
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do begin
      @(negedge clk);
      got = cfg_ready;
      @(posedge clk);
    end while (!got);
    sb.write_reg(idx, val);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  // one row of random pairs; mostly near neighbors, some anywhere
  task automatic random_row(output int n);
    logic signed [31:0] ix, iy, iz, jx, jy, jz;
    n = $urandom_range(1, 8);
    ix = $urandom; iy = $urandom; iz = $urandom;
    if ($urandom_range(3) == 0) begin
      ix = ix >>> $urandom_range(31);
      iy = iy >>> $urandom_range(31);
      iz = iz >>> $urandom_range(31);
    end
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(4) == 0) begin
        jx = $urandom; jy = $urandom; jz = $urandom;
      end else begin
        jx = ix + ($signed($urandom) >>> $urandom_range(6, 31));
        jy = iy + ($signed($urandom) >>> $urandom_range(6, 31));
        jz = iz + ($signed($urandom) >>> $urandom_range(6, 31));
      end
      send_pair(ix, iy, iz, jx, jy, jz, k == n - 1);
    end
  endtask

  task automatic random_phase(int pairs);
    int sent;
    int n;
    sent = 0;
    while (sent < pairs) begin
      random_row(n);
      sent = sent + n;
      // hold off until the core has caught up with every row
      if ($urandom_range(40) == 0) begin
        in_valid <= 0;
        @(posedge clk);
        while (sb.owed.size() != 0) @(posedge clk);
      end
    end
  endtask

  localparam logic signed [31:0] PMAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] PMIN = -32'sh8000_0000;

  initial begin
    send_idle = 13;
    recv_idle = 56;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: reset registers, widest spans both ways, coincident pair
    send_pair(PMAX, PMAX, PMAX, PMIN, PMIN, PMIN, 1);
    send_pair(PMIN, PMIN, PMIN, PMAX, PMAX, PMAX, 0);
    send_pair(PMAX, PMIN, 0, PMIN, PMAX, 0, 1);
    send_pair(32'sd100, -32'sd7, 32'sd3, 32'sd100, -32'sd7, 32'sd3, 1);
    send_pair(0, 0, 0, 32'sh0100_0000, 0, 0, 1);
    drain();
    // no softening: zero distance adds nothing; nor does one LSB, whose square drops out of r2
    write_reg(sgpa_pkg::CFG_SOFTENING, 56'd0);
    write_reg(sgpa_pkg::CFG_MASS, 56'hFFFF_FFFF);
    write_reg(sgpa_pkg::CFG_SELF_POT, 56'h7FFF_FFFF_FFFF);
    write_reg(CFG_UNUSED, 56'hFF_FFFF_FFFF_FFFF);
    send_pair(5, 5, 5, 5, 5, 5, 1);
    send_pair(0, 0, 0, 1, 0, 0, 1);
    for (int k = 0; k < 4; k++) send_pair(1, 0, -1, 0, 1, 0, k == 3);
    send_pair(PMIN, PMAX, PMIN, PMIN, PMAX, PMIN, 0);
    send_pair(0, 1, 0, 0, 0, 0, 1);
    drain();
    // widest softening, no mass, no self term
    write_reg(sgpa_pkg::CFG_SOFTENING, 56'hFF_FFFF_FFFF_FFFF);
    write_reg(sgpa_pkg::CFG_MASS, 56'd0);
    write_reg(sgpa_pkg::CFG_SELF_POT, 56'd0);
    send_pair(PMAX, 0, PMIN, 0, PMAX, 0, 1);
    drain();
    write_reg(sgpa_pkg::CFG_MASS, 56'd1);
    send_pair(3, 2, 1, -3, -2, -1, 1);
    drain();

    // random phase one: reset-like registers
    write_reg(sgpa_pkg::CFG_SOFTENING, 56'd6200640000);
    write_reg(sgpa_pkg::CFG_MASS, 56'd167772);
    write_reg(sgpa_pkg::CFG_SELF_POT, 56'd9150857321);
    random_phase(620);
    drain();

    // phase two: roles of the idlers swapped, random registers
    send_idle = 56;
    recv_idle = 13;
    write_reg(sgpa_pkg::CFG_SOFTENING,
              56'({$urandom, $urandom} & 64'h00_00FF_FFFF_FFFF));
    write_reg(sgpa_pkg::CFG_MASS, 56'($urandom));
    write_reg(sgpa_pkg::CFG_SELF_POT,
              56'({$urandom, $urandom} & 64'h7FFF_FFFF_FFFF));
    random_phase(620);
    drain();

    // phase three: full rate, small softening and heavy mass
    send_idle = 0;
    recv_idle = 0;
    write_reg(sgpa_pkg::CFG_SOFTENING, 56'd1);
    write_reg(sgpa_pkg::CFG_MASS, 56'h00FF_FFFF);
    random_phase(620);
    drain();

    if (sb.errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("testbench failed");
    $finish;
  end

endmodule
